// ===== design/dwq_pkg.sv =====
package dwq_pkg;

  // Command codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Result status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd1;
  localparam logic [16:0] TPS_RESET      = 17'd1000;
  localparam logic [15:0] INTERVAL_RESET = 16'd250;

  // Results per service pass
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  work_id;
    logic [11:0] delay_seconds;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_id;
    logic       status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] deadline;
  } tentry_t;

  // a strictly before b, wrap-aware
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ===== design/dwq_ram.sv =====
module dwq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, data holds while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dwq_ctrl.sv =====
module dwq_ctrl #(
  parameter int TIMED_DEPTH     = 16,
  parameter int IMMEDIATE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [16:0]                        tps,
  input  logic [15:0]                        interval,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  dwq_pkg::cmd_t                      cmd,
  output logic                               res_valid,
  input  logic                               res_stall,
  output dwq_pkg::res_t                      res,
  output logic                               t_we,
  output logic [$clog2(TIMED_DEPTH)-1:0]     t_waddr,
  output dwq_pkg::tentry_t                   t_wdata,
  output logic                               t_re,
  output logic [$clog2(TIMED_DEPTH)-1:0]     t_raddr,
  input  dwq_pkg::tentry_t                   t_rdata,
  output logic                               i_we,
  output logic [$clog2(IMMEDIATE_DEPTH)-1:0] i_waddr,
  output logic [7:0]                         i_wdata,
  output logic                               i_re,
  output logic [$clog2(IMMEDIATE_DEPTH)-1:0] i_raddr,
  input  logic [7:0]                         i_rdata
);

  localparam int TAW  = $clog2(TIMED_DEPTH);
  localparam int IAW  = $clog2(IMMEDIATE_DEPTH);
  localparam int MAXD = (TIMED_DEPTH > IMMEDIATE_DEPTH) ? TIMED_DEPTH : IMMEDIATE_DEPTH;
  localparam int IW   = $clog2(MAXD + 1);
  localparam int TCW  = $clog2(TIMED_DEPTH + 1);
  localparam int ICW  = $clog2(IMMEDIATE_DEPTH + 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DECODE  = 18'h00002,
    S_RM_RD   = 18'h00004,
    S_RM_EV   = 18'h00008,
    S_ADD     = 18'h00010,
    S_REJ     = 18'h00020,
    S_FIND_RD = 18'h00040,
    S_FIND_EV = 18'h00080,
    S_SHIFT   = 18'h00100,
    S_SH_EV   = 18'h00200,
    S_INS     = 18'h00400,
    S_P_IRD   = 18'h00800,
    S_P_IEV   = 18'h01000,
    S_P_TRD   = 18'h02000,
    S_P_TEV   = 18'h04000,
    S_C_RD    = 18'h08000,
    S_C_EV    = 18'h10000,
    S_FLUSH   = 18'h20000
  } state_t;

  state_t                           state;
  dwq_pkg::cmd_t                    item;
  logic [28:0]                      prod;
  logic [31:0]                      when_t;
  logic [31:0]                      time_now;
  logic [15:0]                      interval_count;
  logic                             pending;
  logic [TCW-1:0]                   tcount;
  logic [ICW-1:0]                   icount;
  logic                             sel;
  logic                             found;
  logic [IW-1:0]                    idx;
  logic [IW-1:0]                    pos;
  logic [IW-1:0]                    drained;
  logic [dwq_pkg::RES_CNT_W-1:0]    nres;
  logic                             hv;
  logic [7:0]                       hid;

  logic                             can_emit;
  logic                             emit_en;
  dwq_pkg::res_t                    emit_item;
  logic [IW-1:0]                    idx_m1;
  logic [IW-1:0]                    idx_c;
  logic [IW-1:0]                    cur_count;
  logic [7:0]                       cur_id;
  logic [15:0]                      icnt_inc;
  logic                             due;
  logic                             cap_hit;

  assign cmd_stall = (state != S_IDLE);
  assign can_emit  = !res_valid || !res_stall;
  assign idx_m1    = idx - 1'b1;
  assign idx_c     = idx - drained;
  assign cur_count = sel ? IW'(icount) : IW'(tcount);
  assign cur_id    = sel ? i_rdata : t_rdata.id;
  assign icnt_inc  = interval_count + 16'd1;
  assign due       = !dwq_pkg::is_before(time_now, t_rdata.deadline);
  assign cap_hit   = (nres == dwq_pkg::RES_CNT_W'(dwq_pkg::MAX_RESULTS));

  // Memory port and result drive per state
  always_comb begin
    t_we      = 1'b0;
    t_waddr   = idx[TAW-1:0];
    t_wdata   = t_rdata;
    t_re      = 1'b0;
    t_raddr   = idx[TAW-1:0];
    i_we      = 1'b0;
    i_waddr   = idx_m1[IAW-1:0];
    i_wdata   = i_rdata;
    i_re      = 1'b0;
    i_raddr   = idx[IAW-1:0];
    emit_en   = 1'b0;
    emit_item = '{out_id: hid, status: dwq_pkg::STATUS_DONE, last: 1'b0};
    unique case (state)
      S_RM_RD: begin
        if (idx != cur_count) begin
          t_re = !sel;
          i_re = sel;
        end
      end
      S_RM_EV: begin
        if (found) begin
          t_we    = !sel;
          t_waddr = idx_m1[TAW-1:0];
          i_we    = sel;
        end
      end
      S_ADD: begin
        if (item.delay_seconds == 12'd0 && icount != ICW'(IMMEDIATE_DEPTH)) begin
          i_we    = 1'b1;
          i_waddr = icount[IAW-1:0];
          i_wdata = item.work_id;
        end
      end
      S_REJ: begin
        emit_en   = can_emit;
        emit_item = '{out_id: item.work_id, status: dwq_pkg::STATUS_REJECT, last: 1'b1};
      end
      S_FIND_RD: begin
        t_re = (idx != IW'(tcount));
      end
      S_SHIFT: begin
        t_re    = (idx != pos);
        t_raddr = idx_m1[TAW-1:0];
      end
      S_SH_EV: begin
        t_we = 1'b1;
      end
      S_INS: begin
        t_we    = 1'b1;
        t_waddr = pos[TAW-1:0];
        t_wdata = '{id: item.work_id, deadline: when_t};
      end
      S_P_IRD: begin
        i_re = (idx != IW'(icount));
      end
      S_P_IEV: begin
        emit_en = hv && can_emit;
      end
      S_P_TRD: begin
        t_re = (idx != IW'(tcount));
      end
      S_P_TEV: begin
        emit_en = due && !cap_hit && hv && can_emit;
      end
      S_C_RD: begin
        t_re = (idx != IW'(tcount)) && (drained != '0);
      end
      S_C_EV: begin
        t_we    = 1'b1;
        t_waddr = idx_c[TAW-1:0];
      end
      S_FLUSH: begin
        emit_en        = hv && can_emit;
        emit_item.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_en) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      res <= emit_item;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      time_now       <= '0;
      interval_count <= '0;
      pending        <= 1'b0;
      tcount         <= '0;
      icount         <= '0;
      hv             <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd;
            prod  <= 29'(cmd.delay_seconds) * 29'(tps);
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          sel   <= 1'b0;
          idx   <= '0;
          found <= 1'b0;
          case (item.kind)
            dwq_pkg::KIND_ADD, dwq_pkg::KIND_CANCEL: state <= S_RM_RD;
            dwq_pkg::KIND_TICK: begin
              time_now <= time_now + 32'd1;
              if (icnt_inc >= interval) begin
                interval_count <= '0;
              end else begin
                interval_count <= icnt_inc;
              end
              if (pending || icnt_inc >= interval) begin
                pending <= 1'b0;
                nres    <= '0;
                state   <= S_P_IRD;
              end else begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_RM_RD: begin
          if (idx == cur_count) begin
            if (found && !sel) tcount <= tcount - 1'b1;
            if (found && sel) icount <= icount - 1'b1;
            idx   <= '0;
            found <= 1'b0;
            if (!sel) begin
              sel   <= 1'b1;
            end else if (item.kind == dwq_pkg::KIND_CANCEL) begin
              state <= S_IDLE;
            end else begin
              state <= S_ADD;
            end
          end else begin
            state <= S_RM_EV;
          end
        end
        S_RM_EV: begin
          if (!found && cur_id == item.work_id) found <= 1'b1;
          idx   <= idx + 1'b1;
          state <= S_RM_RD;
        end
        S_ADD: begin
          when_t <= time_now + 32'(prod);
          idx    <= '0;
          if (item.delay_seconds == 12'd0) begin
            if (icount == ICW'(IMMEDIATE_DEPTH)) begin
              state <= S_REJ;
            end else begin
              icount  <= icount + 1'b1;
              pending <= 1'b1;
              state   <= S_IDLE;
            end
          end else if (tcount == TCW'(TIMED_DEPTH)) begin
            state <= S_REJ;
          end else begin
            state <= S_FIND_RD;
          end
        end
        S_REJ: begin
          if (can_emit) state <= S_IDLE;
        end
        S_FIND_RD: begin
          if (idx == IW'(tcount)) begin
            pos   <= idx;
            state <= S_SHIFT;
          end else begin
            state <= S_FIND_EV;
          end
        end
        S_FIND_EV: begin
          if (dwq_pkg::is_before(when_t, t_rdata.deadline)) begin
            pos   <= idx;
            idx   <= IW'(tcount);
            state <= S_SHIFT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FIND_RD;
          end
        end
        S_SHIFT: begin
          state <= (idx == pos) ? S_INS : S_SH_EV;
        end
        S_SH_EV: begin
          idx   <= idx_m1;
          state <= S_SHIFT;
        end
        S_INS: begin
          tcount <= tcount + 1'b1;
          state  <= S_IDLE;
        end
        S_P_IRD: begin
          if (idx == IW'(icount)) begin
            icount <= '0;
            idx    <= '0;
            state  <= S_P_TRD;
          end else begin
            state <= S_P_IEV;
          end
        end
        S_P_IEV: begin
          if (!hv || can_emit) begin
            hv    <= 1'b1;
            hid   <= i_rdata;
            nres  <= nres + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_P_IRD;
          end
        end
        S_P_TRD: begin
          if (idx == IW'(tcount)) begin
            drained <= idx;
            state   <= S_C_RD;
          end else begin
            state <= S_P_TEV;
          end
        end
        S_P_TEV: begin
          if (!due) begin
            drained <= idx;
            state   <= S_C_RD;
          end else if (cap_hit) begin
            pending <= 1'b1;
            drained <= idx;
            state   <= S_C_RD;
          end else if (!hv || can_emit) begin
            hv    <= 1'b1;
            hid   <= t_rdata.id;
            nres  <= nres + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_P_TRD;
          end
        end
        S_C_RD: begin
          if (idx == IW'(tcount) || drained == '0) begin
            tcount <= tcount - TCW'(drained);
            state  <= S_FLUSH;
          end else begin
            state <= S_C_EV;
          end
        end
        S_C_EV: begin
          idx   <= idx + 1'b1;
          state <= S_C_RD;
        end
        S_FLUSH: begin
          if (!hv) begin
            state <= S_IDLE;
          end else if (can_emit) begin
            hv    <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/deadline_work_queue.sv =====
// Deferred-work scheduler. Each command (add, cancel, tick) is taken when
// the block is idle and worked through by a sequencer over two synchronous
// memories, the deadline-sorted timed list and the immediate list, with one
// read a cycle and registered read data. A cancel and an add scan both
// lists entry by entry; a timed add also scans for its place and moves the
// later entries up; a service pass compacts the timed entries left behind
// through the same memory port. Results leave through an output register,
// one per cycle at most, and a pass gives at most 32 of them; the final
// result of each command carries last. No clearing pass follows reset.
module deadline_work_queue #(
  parameter int TIMED_DEPTH     = 16,
  parameter int IMMEDIATE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dwq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  dwq_pkg::cmd_t                    cmd,
  output logic                             res_valid,
  input  logic                             res_stall,
  output dwq_pkg::res_t                    res
);

  localparam int TAW = $clog2(TIMED_DEPTH);
  localparam int IAW = $clog2(IMMEDIATE_DEPTH);

  logic [16:0]      tps;
  logic [15:0]      interval;
  logic             t_we;
  logic [TAW-1:0]   t_waddr;
  dwq_pkg::tentry_t t_wdata;
  logic             t_re;
  logic [TAW-1:0]   t_raddr;
  dwq_pkg::tentry_t t_rdata;
  logic             i_we;
  logic [IAW-1:0]   i_waddr;
  logic [7:0]       i_wdata;
  logic             i_re;
  logic [IAW-1:0]   i_raddr;
  logic [7:0]       i_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tps      <= dwq_pkg::TPS_RESET;
      interval <= dwq_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dwq_pkg::CFG_TPS:      tps      <= cfg_data[16:0];
        dwq_pkg::CFG_INTERVAL: interval <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dwq_ctrl #(
    .TIMED_DEPTH     (TIMED_DEPTH),
    .IMMEDIATE_DEPTH (IMMEDIATE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tps       (tps),
    .interval  (interval),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .t_we      (t_we),
    .t_waddr   (t_waddr),
    .t_wdata   (t_wdata),
    .t_re      (t_re),
    .t_raddr   (t_raddr),
    .t_rdata   (t_rdata),
    .i_we      (i_we),
    .i_waddr   (i_waddr),
    .i_wdata   (i_wdata),
    .i_re      (i_re),
    .i_raddr   (i_raddr),
    .i_rdata   (i_rdata)
  );

  dwq_ram #(
    .W ($bits(dwq_pkg::tentry_t)),
    .D (TIMED_DEPTH)
  ) u_timed_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dwq_ram #(
    .W (8),
    .D (IMMEDIATE_DEPTH)
  ) u_imm_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (i_wdata),
    .re    (i_re),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

endmodule

// ===== design/dwq_check.sv =====
module dwq_check (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input dwq_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input dwq_pkg::res_t res
);

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A rejected add is always the only and final result
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == dwq_pkg::STATUS_REJECT |-> res.last)
    else $error("reject without last");

  // Block is busy the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("item taken without busy cycle");

endmodule

bind deadline_work_queue dwq_check u_dwq_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam int TLIST_DEPTH = 16;
  localparam int ILIST_DEPTH = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3000000;
  // kind code with no command behind it
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [dwq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dwq_pkg::CFG_DATA_W-1:0] cfg_data;
  logic cmd_valid;
  logic cmd_stall;
  dwq_pkg::cmd_t cmd;
  logic res_valid;
  logic res_stall;
  dwq_pkg::res_t res;

  deadline_work_queue i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // scheduler shadow state
  logic [16:0] sh_tps;
  logic [15:0] sh_interval;
  logic [31:0] sh_now;
  logic [15:0] sh_icount;
  logic sh_pending;
  logic [7:0] sh_tids [TLIST_DEPTH];
  logic [31:0] sh_tdl [TLIST_DEPTH];
  int sh_tcnt;
  logic [7:0] sh_iids [ILIST_DEPTH];
  int sh_icnt;

  dwq_pkg::cmd_t work_q[$];
  dwq_pkg::res_t dispatch_q[$];
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_go;
  int hold_left;
  int errors;
  int cycles;

  function automatic logic earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void drop_id(logic [7:0] id);
    int i;
    for (i = 0; i < sh_tcnt; i++) begin
      if (sh_tids[i] == id) begin
        for (int j = i; j + 1 < sh_tcnt; j++) begin
          sh_tids[j] = sh_tids[j+1];
          sh_tdl[j] = sh_tdl[j+1];
        end
        sh_tcnt--;
        break;
      end
    end
    for (i = 0; i < sh_icnt; i++) begin
      if (sh_iids[i] == id) begin
        for (int j = i; j + 1 < sh_icnt; j++) sh_iids[j] = sh_iids[j+1];
        sh_icnt--;
        break;
      end
    end
  endfunction

  function automatic logic head_due();
    return sh_tcnt > 0 && !earlier(sh_now, sh_tdl[0]);
  endfunction

  // work out the results of one accepted item and queue them
  function automatic void schedule_item(dwq_pkg::cmd_t c);
    dwq_pkg::res_t outs[$];
    dwq_pkg::res_t r;
    logic go;
    logic [31:0] when;
    int pos;
    if (c.kind == dwq_pkg::KIND_ADD) begin
      drop_id(c.work_id);
      if (c.delay_seconds == 12'd0) begin
        if (sh_icnt >= ILIST_DEPTH) begin
          r.out_id = c.work_id; r.status = dwq_pkg::STATUS_REJECT; r.last = 1'b0;
          outs.push_back(r);
        end else begin
          sh_iids[sh_icnt] = c.work_id;
          sh_icnt++;
          sh_pending = 1'b1;
        end
      end else begin
        when = sh_now + 32'(c.delay_seconds) * 32'(sh_tps);
        if (sh_tcnt >= TLIST_DEPTH) begin
          r.out_id = c.work_id; r.status = dwq_pkg::STATUS_REJECT; r.last = 1'b0;
          outs.push_back(r);
        end else begin
          pos = 0;
          while (pos < sh_tcnt && !earlier(when, sh_tdl[pos])) pos++;
          for (int i = sh_tcnt; i > pos; i--) begin
            sh_tids[i] = sh_tids[i-1];
            sh_tdl[i] = sh_tdl[i-1];
          end
          sh_tids[pos] = c.work_id;
          sh_tdl[pos] = when;
          sh_tcnt++;
        end
      end
    end else if (c.kind == dwq_pkg::KIND_CANCEL) begin
      drop_id(c.work_id);
    end else if (c.kind == dwq_pkg::KIND_TICK) begin
      go = sh_pending;
      sh_now = sh_now + 32'd1;
      sh_icount = sh_icount + 16'd1;
      if (sh_icount >= sh_interval) begin
        sh_icount = '0;
        go = 1'b1;
      end
      if (go) begin
        sh_pending = 1'b0;
        while (sh_icnt > 0 && outs.size() < dwq_pkg::MAX_RESULTS) begin
          r.out_id = sh_iids[0]; r.status = dwq_pkg::STATUS_DONE; r.last = 1'b0;
          outs.push_back(r);
          for (int j = 0; j + 1 < sh_icnt; j++) sh_iids[j] = sh_iids[j+1];
          sh_icnt--;
        end
        while (outs.size() < dwq_pkg::MAX_RESULTS && head_due()) begin
          r.out_id = sh_tids[0]; r.status = dwq_pkg::STATUS_DONE; r.last = 1'b0;
          outs.push_back(r);
          for (int j = 0; j + 1 < sh_tcnt; j++) begin
            sh_tids[j] = sh_tids[j+1];
            sh_tdl[j] = sh_tdl[j+1];
          end
          sh_tcnt--;
        end
        if (sh_icnt > 0 || head_due()) sh_pending = 1'b1;
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) dispatch_q.push_back(outs[i]);
  endfunction

  function automatic dwq_pkg::cmd_t mk(logic [1:0] k, logic [7:0] id, logic [11:0] d);
    dwq_pkg::cmd_t c;
    c.kind = k; c.work_id = id; c.delay_seconds = d;
    return c;
  endfunction

  // mostly adds and ticks over a small id pool, with some noise
  function automatic dwq_pkg::cmd_t rand_item();
    int sel;
    logic [7:0] id;
    logic [11:0] d;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
    case ($urandom_range(0, 9))
      0, 1, 2: d = '0;
      3: d = 12'($urandom);
      4: d = 12'hFFF;
      default: d = 12'($urandom_range(1, 4));
    endcase
    if (sel < 45) return mk(dwq_pkg::KIND_ADD, id, d);
    if (sel < 57) return mk(dwq_pkg::KIND_CANCEL, id, 12'($urandom));
    if (sel < 97) return mk(dwq_pkg::KIND_TICK, 8'($urandom), 12'($urandom));
    return mk(KIND_SPARE, 8'($urandom), 12'($urandom));
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sender: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) schedule_item(cmd);
      if (work_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd <= work_q.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: stall at random or through a long hold, check each result
  always @(posedge clk) begin
    dwq_pkg::res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_go && hold_left == 0) hold_left <= 400;
      else if (hold_left > 1) hold_left <= hold_left - 1;
      res_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_idle_pct);
      if (res_valid && !res_stall) begin
        if (dispatch_q.size() == 0) begin
          $error("unexpected result id %0d", res.out_id);
          errors++;
        end else begin
          want = dispatch_q.pop_front();
          if (res.out_id !== want.out_id) begin
            $error("out_id: expected %0d, got %0d", want.out_id, res.out_id);
            errors++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            errors++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res.last);
            errors++;
          end
        end
      end
    end
  end

  // look at the queues away from the rising edge, once every update has settled
  task automatic wait_idle();
    while (work_q.size() != 0 || cmd_valid || dispatch_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [16:0] tps, logic [15:0] interval);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= dwq_pkg::CFG_TPS; cfg_data <= tps;
    @(posedge clk);
    cfg_index <= dwq_pkg::CFG_INTERVAL; cfg_data <= 17'(interval);
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_tps = tps;
    sh_interval = interval;
  endtask

  initial begin
    logic [16:0] tps_set [4];
    logic [15:0] ivl_set [4];
    tps_set = '{17'd1, 17'd0, 17'd100000, 17'd2};
    ivl_set = '{16'd3, 16'd65535, 16'd1, 16'd0};
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0; cmd = '0;
    hold_go = 0; errors = 0; cycles = 0;
    send_idle_pct = 12; recv_idle_pct = 86;
    sh_tps = dwq_pkg::TPS_RESET; sh_interval = dwq_pkg::INTERVAL_RESET;
    sh_now = '0; sh_icount = '0; sh_pending = 1'b0; sh_tcnt = 0; sh_icnt = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: default rates first, then a short interval
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd0, 12'd0));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd255, 12'hFFF));
    work_q.push_back(mk(dwq_pkg::KIND_TICK, 8'hFF, 12'hFFF));
    wait_idle();
    write_cfg(tps_set[0], ivl_set[0]);
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd7, 12'd1));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd7, 12'd2));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd8, 12'd2));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd9, 12'd2));
    work_q.push_back(mk(dwq_pkg::KIND_CANCEL, 8'd99, 12'd0));
    work_q.push_back(mk(dwq_pkg::KIND_CANCEL, 8'd255, 12'hFFF));
    work_q.push_back(mk(KIND_SPARE, 8'hAA, 12'h555));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd1, 12'd0));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd1, 12'd1));
    work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'd9, 12'd0));
    repeat (6) work_q.push_back(mk(dwq_pkg::KIND_TICK, 8'h00, 12'h000));
    for (int i = 0; i < 17; i++) begin
      work_q.push_back(mk(dwq_pkg::KIND_ADD, 8'(40 + i), 12'd0));
    end
    work_q.push_back(mk(dwq_pkg::KIND_TICK, 8'h00, 12'h000));

    // random phases, each under its own rates; the last two share their idling
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_cfg(tps_set[p], ivl_set[p]);
      if (p == 1) begin
        send_idle_pct = 86; recv_idle_pct = 12;
      end else if (p >= 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 90; i++) work_q.push_back(rand_item());
      if (p == 2) begin
        @(posedge clk);
        hold_go <= 1;
        @(posedge clk);
        hold_go <= 0;
      end
    end
    wait_idle();
    if (errors == 0 && dispatch_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
